// ----- rtl/core/ldns_pkg.sv -----
// ============================================================================
// ldns_pkg
// Shared types for the non-negative linear Diophantine solver.
// ============================================================================
package ldns_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FIN
    } state_t;

    // which operation the shared units are working on
    typedef enum logic [3:0] {
        PH_TRIV_DIV,
        PH_EU_DIV,
        PH_EU_MUL,
        PH_D_DIV,
        PH_BP_DIV,
        PH_SM_DIV,
        PH_NPM_DIV,
        PH_XN_MUL,
        PH_X_DIV,
        PH_AX_MUL,
        PH_Y_DIV
    } phase_t;

    // divider request
    typedef struct packed {
        logic start;
        logic wide;
    } div_req_t;

endpackage

// ----- rtl/core/linear_diophantine_nonneg_solver_core.sv -----
// ============================================================================
// linear_diophantine_nonneg_solver_core
// Solves a*x + b*y = n for the smallest x >= 0 with y >= 0, using an
// extended Euclidean loop on one shared divider and one shared multiplier.
// ============================================================================
//
//  channel  signals                         direction  transfer when
//  -------  ------------------------------  ---------  ----------------------
//  in       coef_a, coef_b, target          into core  in_valid & in_ready
//  out      solvable, x_count, y_count      out of core out_valid & out_ready
//
//  Time per item grows with k, the number of Euclid quotient steps (at most
//  about 35 for 24-bit words). The bit-serial divider sets it: each Euclid
//  step and each other quotient runs through it, the final modular reduction
//  with a double-width dividend. A zero b takes one division only; both
//  coefficients zero bypass the units.
//  Reset: rst_n clears the sequencer and the output valid; no clearing pass.
//  in_ready is high only in IDLE. A finished result sits in the output
//  register; the core takes the next item while it waits, and holds a newly
//  finished result in FIN until the output register is free.
//
module linear_diophantine_nonneg_solver_core
    import ldns_pkg::*;
#(
    parameter int WORD_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_BITS-1:0]  coef_a,
    input  logic [WORD_BITS-1:0]  coef_b,
    input  logic [WORD_BITS-1:0]  target,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  solvable,
    output logic [WORD_BITS-1:0]  x_count,
    output logic [WORD_BITS-1:0]  y_count
);

    localparam int W  = WORD_BITS;
    localparam int IW = $clog2(4 * W + 1);
    localparam logic [IW-1:0] ITER_MAX = IW'(4 * W);

    // ------------------------------------------------------------------
    // sequencer and working registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [W-1:0]        a_reg, b_reg, n_reg;
    logic [W-1:0]        r0_reg, r1_reg;      // Euclid remainders; r0 ends as gcd
    logic signed [W:0]   s0_reg, s1_reg;      // Bezout coefficients of a
    logic [W-1:0]        q_reg;
    logic [W-1:0]        np_reg;              // n / d
    logic [W-1:0]        bp_reg;              // b / d
    logic [W-1:0]        xm_reg;              // s0 mod bp
    logic [W-1:0]        npm_reg;             // np mod bp
    logic [W-1:0]        x_reg;
    logic [IW-1:0]       iter_reg;

    logic                res_ok_reg;
    logic [W-1:0]        res_x_reg, res_y_reg;

    logic                out_valid_reg;
    logic                solvable_reg;
    logic [W-1:0]        x_count_reg, y_count_reg;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    div_req_t            div_req;
    logic [2*W-1:0]      div_dvd;
    logic [W-1:0]        div_dsr;
    logic                div_done;
    logic [2*W-1:0]      div_quot;
    logic [W-1:0]        div_rem;

    logic                mul_start;
    logic signed [W:0]   mul_a, mul_b;
    logic                mul_done;
    logic signed [2*W+1:0] mul_prod;

    ldns_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    ldns_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // ------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------
    logic                in_xfer;
    logic                out_free;
    logic                unit_done;
    logic [IW-1:0]       iter_inc;
    logic [W-1:0]        s0_abs;
    logic [W:0]          s0_neg;
    logic                ax_over;
    logic [W-1:0]        ny_diff;

    always_comb
    begin
        in_xfer   = in_valid && in_ready;
        out_free  = !out_valid_reg || out_ready;
        unit_done = div_done || mul_done;
        iter_inc  = iter_reg + 1'b1;
        s0_neg    = -s0_reg;
        s0_abs    = s0_reg[W] ? s0_neg[W-1:0] : s0_reg[W-1:0];
        // a*x against n, and n - a*x once it is known to fit
        ax_over   = mul_prod[2*W-1:0] > {{W{1'b0}}, n_reg};
        ny_diff   = n_reg - mul_prod[W-1:0];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (coef_a == '0 && coef_b == '0)
                        state_next = ST_FIN;
                    else
                    begin
                        state_next = ST_ISSUE;
                        phase_next = (coef_b == '0) ? PH_TRIV_DIV : PH_EU_DIV;
                    end
                end
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = ST_ISSUE;
                    unique case (phase_reg)
                        PH_TRIV_DIV: state_next = ST_FIN;
                        PH_EU_DIV:   phase_next = PH_EU_MUL;
                        PH_EU_MUL:
                            phase_next = (iter_inc < ITER_MAX && r1_reg != '0)
                                         ? PH_EU_DIV : PH_D_DIV;
                        PH_D_DIV:
                        begin
                            if (div_rem != '0)
                                state_next = ST_FIN;
                            else
                                phase_next = PH_BP_DIV;
                        end
                        PH_BP_DIV:   phase_next = PH_SM_DIV;
                        PH_SM_DIV:   phase_next = PH_NPM_DIV;
                        PH_NPM_DIV:  phase_next = PH_XN_MUL;
                        PH_XN_MUL:   phase_next = PH_X_DIV;
                        PH_X_DIV:    phase_next = PH_AX_MUL;
                        PH_AX_MUL:
                        begin
                            if (ax_over)
                                state_next = ST_FIN;
                            else
                                phase_next = PH_Y_DIV;
                        end
                        PH_Y_DIV:    state_next = ST_FIN;
                        default:     state_next = ST_FIN;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // unit requests and handshake outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        div_req.start = 1'b0;
        div_req.wide  = 1'b0;
        div_dvd       = '0;
        div_dsr       = '0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        if (state_reg == ST_ISSUE)
        begin
            unique case (phase_reg)
                PH_TRIV_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, n_reg};
                    div_dsr       = a_reg;
                end
                PH_EU_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, r0_reg};
                    div_dsr       = r1_reg;
                end
                PH_EU_MUL:
                begin
                    mul_start = 1'b1;
                    mul_a     = {1'b0, q_reg};
                    mul_b     = s1_reg;
                end
                PH_D_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, n_reg};
                    div_dsr       = r0_reg;
                end
                PH_BP_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, b_reg};
                    div_dsr       = r0_reg;
                end
                PH_SM_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, s0_abs};
                    div_dsr       = bp_reg;
                end
                PH_NPM_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, np_reg};
                    div_dsr       = bp_reg;
                end
                PH_XN_MUL:
                begin
                    mul_start = 1'b1;
                    mul_a     = {1'b0, xm_reg};
                    mul_b     = {1'b0, npm_reg};
                end
                PH_X_DIV:
                begin
                    div_req.start = 1'b1;
                    div_req.wide  = 1'b1;
                    div_dvd       = mul_prod[2*W-1:0];
                    div_dsr       = bp_reg;
                end
                PH_AX_MUL:
                begin
                    mul_start = 1'b1;
                    mul_a     = {1'b0, a_reg};
                    mul_b     = {1'b0, x_reg};
                end
                PH_Y_DIV:
                begin
                    div_req.start = 1'b1;
                    div_dvd       = {{W{1'b0}}, ny_diff};
                    div_dsr       = b_reg;
                end
                default:
                begin
                    div_req.start = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_EU_DIV;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (in_xfer)
                iter_reg <= '0;
            else if (state_reg == ST_WAIT && unit_done && phase_reg == PH_EU_MUL)
                iter_reg <= iter_inc;
            // drop valid on transfer, raise it when a finished result loads
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_reg      <= coef_a;
            b_reg      <= coef_b;
            n_reg      <= target;
            r0_reg     <= coef_a;
            r1_reg     <= coef_b;
            s0_reg     <= (W+1)'(1);
            s1_reg     <= '0;
            // only the all-zero case finishes without the units
            res_ok_reg <= (target == '0);
            res_x_reg  <= '0;
            res_y_reg  <= '0;
        end
        else if (state_reg == ST_WAIT && unit_done)
        begin
            case (phase_reg)
                PH_TRIV_DIV:
                begin
                    res_ok_reg <= (div_rem == '0);
                    res_x_reg  <= (div_rem == '0) ? div_quot[W-1:0] : '0;
                    res_y_reg  <= '0;
                end
                PH_EU_DIV:
                begin
                    q_reg  <= div_quot[W-1:0];
                    r0_reg <= r1_reg;
                    r1_reg <= div_rem;
                end
                PH_EU_MUL:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg - mul_prod[W:0];
                end
                PH_D_DIV:
                begin
                    np_reg     <= div_quot[W-1:0];
                    res_ok_reg <= 1'b0;
                    res_x_reg  <= '0;
                    res_y_reg  <= '0;
                end
                PH_BP_DIV:
                    bp_reg <= div_quot[W-1:0];
                PH_SM_DIV:
                    // fold a negative coefficient into [0, bp)
                    xm_reg <= (s0_reg[W] && div_rem != '0) ? bp_reg - div_rem : div_rem;
                PH_NPM_DIV:
                    npm_reg <= div_rem;
                PH_X_DIV:
                    x_reg <= div_rem;
                PH_Y_DIV:
                begin
                    res_ok_reg <= 1'b1;
                    res_x_reg  <= x_reg;
                    res_y_reg  <= div_quot[W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            solvable_reg <= res_ok_reg;
            x_count_reg  <= res_x_reg;
            y_count_reg  <= res_y_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign solvable  = solvable_reg;
    assign x_count   = x_count_reg;
    assign y_count   = y_count_reg;

endmodule

// ----- rtl/core/ldns_div.sv -----
// ============================================================================
// ldns_div
// Restoring divider, one quotient bit per cycle; W or 2W bit dividend.
// ============================================================================
module ldns_div
    import ldns_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  div_req_t        req,
    input  logic [2*W-1:0]  dividend,
    input  logic [W-1:0]    divisor,
    output logic            done,
    output logic [2*W-1:0]  quot,
    output logic [W-1:0]    rem
);

    localparam int CW = $clog2(2 * W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*W-1:0]  dvd_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    dsr_reg;

    logic [W:0]      shift;
    logic            ge;
    logic [W:0]      diff;

    always_comb
    begin
        shift = {rem_reg, dvd_reg[2*W-1]};
        ge    = (shift >= {1'b0, dsr_reg});
        diff  = shift - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.wide ? CW'(2 * W) : CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // short operands start in the upper half so the quotient lands in the lower
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : shift[W-1:0];
            dvd_reg <= {dvd_reg[2*W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/ldns_mul.sv -----
// ============================================================================
// ldns_mul
// Signed multiplier with a registered product and a done strobe.
// ============================================================================
module ldns_mul
    import ldns_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [W:0]      op_a,
    input  logic signed [W:0]      op_b,
    output logic                   done,
    output logic signed [2*W+1:0]  prod
);

    logic                   done_reg;
    logic signed [2*W+1:0]  prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= start;
    end

    // hold the product until the next start
    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= op_a * op_b;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- rtl/core/ldns_chk.sv -----
// ============================================================================
// ldns_chk
// Port-level checks for the solver core, bound to the top level.
// ============================================================================
module ldns_chk
#(
    parameter int W = 24
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic          solvable,
    input logic [W-1:0]  x_count,
    input logic [W-1:0]  y_count
);

    // the core is busy right after taking an item
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solvable)
            && $stable(x_count) && $stable(y_count))
        else $error("stalled result changed");

    // no solution carries zero counts
    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !solvable |-> x_count == '0 && y_count == '0)
        else $error("counts nonzero without a solution");

    // a new result appears only right after the core was busy
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while core was idle");

endmodule

bind linear_diophantine_nonneg_solver_core ldns_chk #(.W(WORD_BITS)) u_ldns_chk (.*);

// ----- test/ldns_checker.sv -----
// ============================================================================
// ldns_checker
// Watches both channels of the Diophantine solver core. Predicts one result
// per input transfer and compares each output transfer with the oldest
// prediction.
// ============================================================================
module ldns_checker #(
    parameter int WORD_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [WORD_BITS-1:0]  coef_a,
    input  logic [WORD_BITS-1:0]  coef_b,
    input  logic [WORD_BITS-1:0]  target,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  solvable,
    input  logic [WORD_BITS-1:0]  x_count,
    input  logic [WORD_BITS-1:0]  y_count,
    output int                    errors,
    output int                    outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 ok;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
    } solution_t;

    solution_t solution_q[$];
    int        results_seen;

    // Smallest non-negative x of a*x + b*y = n with y >= 0, via extended Euclid.
    function automatic solution_t solve_nonneg(input logic [WORD_BITS-1:0] a_in,
                                               input logic [WORD_BITS-1:0] b_in,
                                               input logic [WORD_BITS-1:0] n_in);
        longint unsigned a, b, n, r0, r1, q, rt, d, bp, np, xm, x, ax, y;
        longint          s0, s1, st, sm;
        int              i;
        solution_t       sol;
        a   = a_in;
        b   = b_in;
        n   = n_in;
        sol = '0;
        if (a == 0 && b == 0) begin
            sol.ok = (n == 0);
            return sol;
        end
        if (b == 0) begin
            if (n % a == 0) begin
                x      = n / a;
                sol.ok = 1'b1;
                sol.x  = x[WORD_BITS-1:0];
            end
            return sol;
        end
        // track only the coefficient of a
        r0 = a;
        r1 = b;
        s0 = 1;
        s1 = 0;
        for (i = 0; i < 4 * WORD_BITS && r1 != 0; i++) begin
            q  = r0 / r1;
            rt = r0 - q * r1;
            st = s0 - $signed(q) * s1;
            r0 = r1;
            r1 = rt;
            s0 = s1;
            s1 = st;
        end
        d = r0;
        if (n % d != 0)
            return sol;
        bp = b / d;
        np = n / d;
        sm = s0 % $signed(bp);
        if (sm < 0)
            sm = sm + $signed(bp);
        xm = $unsigned(sm);
        x  = (xm * (np % bp)) % bp;
        ax = a * x;
        if (ax > n)
            return sol;
        y      = (n - ax) / b;
        sol.ok = 1'b1;
        sol.x  = x[WORD_BITS-1:0];
        sol.y  = y[WORD_BITS-1:0];
        return sol;
    endfunction

    initial begin
        errors       = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    always @(posedge clk) begin
        solution_t exp_sol;
        if (rst_n) begin
            // retire first: a result can never belong to the item taken this cycle
            if (out_valid && out_ready) begin
                results_seen++;
                if (solution_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with nothing expected: solvable=%0b x=%0d y=%0d",
                                 results_seen, solvable, x_count, y_count);
                end
                else begin
                    exp_sol = solution_q.pop_front();
                    if (solvable !== exp_sol.ok || x_count !== exp_sol.x
                        || y_count !== exp_sol.y) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d mismatch: expected solvable=%0b x=%0d y=%0d, got solvable=%0b x=%0d y=%0d",
                                     results_seen, exp_sol.ok, exp_sol.x, exp_sol.y,
                                     solvable, x_count, y_count);
                    end
                end
            end
            if (in_valid && in_ready)
                solution_q.push_back(solve_nonneg(coef_a, coef_b, target));
            outstanding <= solution_q.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// testbench
// Drives the non-negative Diophantine solver core with directed corner cases
// and about 1700 random problems (solvable by construction, common factors,
// Fibonacci pairs, plain noise), with random gaps on both channels, one long
// output stall and one full drain. A checker beside the core does the scoring.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              W          = 24;
    localparam longint unsigned WORD_MAX   = (64'd1 << W) - 1;
    localparam int              RANDOM_N   = 1730;
    localparam int              PAUSE_AT   = 865;       // sender drains here
    localparam int              HOLD_AT    = 300;       // receiver stalls here
    localparam int              HOLD_LEN   = 4000;      // several items' worth
    localparam int              DRAIN_LEN  = 1500;      // above worst item latency
    localparam int              CYCLE_CAP  = 12_000_000;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] coef_a;
    logic [W-1:0] coef_b;
    logic [W-1:0] target;
    logic         out_valid;
    logic         out_ready;
    logic         solvable;
    logic [W-1:0] x_count;
    logic [W-1:0] y_count;
    int           errors;
    int           outstanding;
    int           problems_sent;
    int           answers_taken;

    linear_diophantine_nonneg_solver_core #(
        .WORD_BITS (W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .target    (target),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .solvable  (solvable),
        .x_count   (x_count),
        .y_count   (y_count)
    );

    ldns_checker #(
        .WORD_BITS (W)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coef_a      (coef_a),
        .coef_b      (coef_b),
        .target      (target),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .solvable    (solvable),
        .x_count     (x_count),
        .y_count     (y_count),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Offer one problem and hold it until the core takes it. Enter and leave
    // on a falling edge; valid stays high into the next call unless it draws a gap.
    task automatic send_problem(input logic [W-1:0] a, input logic [W-1:0] b,
                                input logic [W-1:0] n);
        int gap;
        // every third block of 150 problems runs back to back
        gap = ((problems_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        coef_a   = a;
        coef_b   = b;
        target   = n;
        // in_ready read here still holds its pre-edge value
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        problems_sent++;
    endtask

    // Receiver: draw a stall per result, with one long hold-off so the core
    // fills its output register and its finished slot and drops in_ready.
    initial begin
        int gap;
        out_ready     = 1'b0;
        answers_taken = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (answers_taken == HOLD_AT) begin
                out_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            else begin
                gap = ((answers_taken / 100) % 4 == 2) ? 0 : $urandom_range(0, 13);
                if (gap > 0) begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            answers_taken++;
        end
    end

    // Watchdog: sized from the slowest legal run several times over.
    initial begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        longint unsigned ta, tb, tn, fa, fb, ft;
        int              mode, g, xs, ys, k, i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        coef_a        = '0;
        coef_b        = '0;
        target        = '0;
        problems_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners: field extremes, zero coefficients, no-divisor and
        // negative-y rejections, longest Euclid chain (consecutive Fibonacci).
        send_problem(1, 1, 1);
        send_problem(WORD_MAX, WORD_MAX, WORD_MAX);
        send_problem(1, WORD_MAX, WORD_MAX);
        send_problem(WORD_MAX, 1, WORD_MAX);
        send_problem(WORD_MAX, WORD_MAX - 1, 1);
        send_problem(1, 1, WORD_MAX);
        send_problem(0, 0, 0);
        send_problem(0, 0, 5);
        send_problem(5, 0, 15);
        send_problem(5, 0, 16);
        send_problem(0, 7, 21);
        send_problem(0, 7, 22);
        send_problem(9227465, 5702887, WORD_MAX);
        send_problem(5702887, 9227465, 12345);
        send_problem(6, 10, 7);
        send_problem(3, 5, 7);
        send_problem(3, 5, 8);
        send_problem(2, 3, 1);
        send_problem(24'h800000, 24'h800000, 24'h800000);
        send_problem(24'h555555, 24'hAAAAAA, 24'hFFFFFE);
        send_problem(24'hAAAAAA, 24'h555555, 24'hFFFFFF);

        for (i = 0; i < RANDOM_N; i++) begin
            // hold off once until every answer is back
            if (i == PAUSE_AT) begin
                in_valid = 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
            end
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2: begin
                    // solvable by construction, small shared factor
                    g  = $urandom_range(1, 64);
                    ta = g * $urandom_range(1, 4095);
                    tb = g * $urandom_range(1, 4095);
                    xs = $urandom_range(0, 15);
                    ys = $urandom_range(0, 15);
                    tn = ta * xs + tb * ys;
                    if (tn == 0)
                        tn = ta;
                end
                3: begin
                    ta = $urandom_range(1, 255);
                    tb = $urandom_range(1, 255);
                    tn = $urandom_range(1, 255);
                end
                4: begin
                    // consecutive Fibonacci numbers force long quotient chains
                    k  = $urandom_range(5, 33);
                    fa = 1;
                    fb = 1;
                    repeat (k) begin
                        ft = fa + fb;
                        fa = fb;
                        fb = ft;
                    end
                    if ($urandom_range(0, 1)) begin
                        ta = fb;
                        tb = fa;
                    end
                    else begin
                        ta = fa;
                        tb = fb;
                    end
                    tn = $urandom_range(1, WORD_MAX);
                end
                5, 6: begin
                    // large coefficients with a common factor
                    g  = $urandom_range(2, 4096);
                    ta = g * $urandom_range(1, WORD_MAX / g);
                    tb = g * $urandom_range(1, WORD_MAX / g);
                    if ($urandom_range(0, 3) == 0)
                        tn = $urandom_range(1, WORD_MAX);
                    else
                        tn = g * $urandom_range(1, WORD_MAX / g);
                end
                7: begin
                    // large coefficients, target built from a small solution
                    ta = $urandom_range(1, WORD_MAX / 4);
                    tb = $urandom_range(1, WORD_MAX / 4);
                    xs = $urandom_range(0, 2);
                    ys = $urandom_range(0, 2);
                    tn = ta * xs + tb * ys;
                    if (tn == 0)
                        tn = tb;
                end
                default: begin
                    ta = $urandom_range(1, WORD_MAX);
                    tb = $urandom_range(1, WORD_MAX);
                    tn = $urandom_range(1, WORD_MAX);
                end
            endcase
            // rare zero coefficients reach the degenerate paths
            if ($urandom_range(0, 79) == 0)
                ta = 0;
            if ($urandom_range(0, 79) == 0)
                tb = 0;
            send_problem(ta[W-1:0], tb[W-1:0], tn[W-1:0]);
        end
        in_valid = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        // let any stray result show up
        repeat (DRAIN_LEN) @(negedge clk);

        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
